// ===== rtl/dtt_pkg.sv =====
// Shared types, codes and helpers of the deadline timer table.
// No dependencies.
package dtt_pkg;

  localparam int unsigned Slots      = 16;
  localparam int unsigned SlotBits   = 4;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned PeriodBits = 32;
  localparam logic [31:0] DefaultWindow = 32'd3600000;  // one hour in ms
  localparam logic [TimeBits-1:0] TimeMax = '1;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_REFRESH = 3'd2,
    OP_RESET   = 3'd3,
    OP_EXPIRE  = 3'd4,
    OP_QUERY   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]            operation;
    logic [SlotBits-1:0]   slot;
    logic [PeriodBits-1:0] period_ms;
    logic                  recurring;
    logic                  restart_now;
    logic [TimeBits-1:0]   now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SlotBits-1:0] result_slot;
    logic                fired;
    logic [TimeBits-1:0] remaining_ms;
    logic                any_armed;
    logic                wake;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [PeriodBits-1:0] period;
    logic [TimeBits-1:0]   deadline;
  } slot_ent_t;

  // time + period, saturating at all ones
  function automatic logic [TimeBits-1:0] sat_add(input logic [TimeBits-1:0] t,
                                                  input logic [PeriodBits-1:0] p);
    logic [TimeBits:0] s;
    s = {1'b0, t} + {{(TimeBits + 1 - PeriodBits){1'b0}}, p};
    return s[TimeBits] ? TimeMax : s[TimeBits-1:0];
  endfunction

  function automatic out_t mk_res(input status_e st, input logic [SlotBits-1:0] sl,
                                  input logic fi, input logic [TimeBits-1:0] rem,
                                  input logic any, input logic wk, input logic la);
    out_t r;
    r.status       = st;
    r.result_slot  = sl;
    r.fired        = fi;
    r.remaining_ms = rem;
    r.any_armed    = any;
    r.wake         = wk;
    r.last         = la;
    return r;
  endfunction

endpackage

// ===== rtl/dtt_slot_ram.sv =====
// Period and deadline store of the timer slots, one write and one read port,
// registered read data. Depends on dtt_pkg.
module dtt_slot_ram import dtt_pkg::*; (
  input  logic                clk_i,
  input  logic                we_period_i,
  input  logic                we_deadline_i,
  input  logic [SlotBits-1:0] waddr_i,
  input  slot_ent_t           wdata_i,
  input  logic [SlotBits-1:0] raddr_i,
  output slot_ent_t           rdata_o
);

  logic [PeriodBits-1:0] per_mem [Slots];
  logic [TimeBits-1:0]   dl_mem  [Slots];

  always_ff @(posedge clk_i) begin
    if (we_period_i) begin
      per_mem[waddr_i] <= wdata_i.period;
    end
    if (we_deadline_i) begin
      dl_mem[waddr_i] <= wdata_i.deadline;
    end
    rdata_o.period   <= per_mem[raddr_i];
    rdata_o.deadline <= dl_mem[raddr_i];
  end

endmodule

// ===== rtl/deadline_timer_table.sv =====
// Deadline timer table: top level with the operation sequencer.
// Depends on dtt_pkg and dtt_slot_ram.
//
// Usage: drive in_i and raise start while busy is low; the word is taken at
// that edge. Results come out on result_o, each for exactly one cycle with
// result_valid_o high; the word with result_o.last ends the item. The
// receiver cannot stall, so results leave at one per cycle.
// Work per operation, from accept to the last result:
//   cancel, refused or unknown operations, full table: result from idle
//   refresh, reset without change: one slot read; reset with change: read, scan
//   add, query: one scan of the 16 slots through the deadline memory
//   expire: one due scan, then per fired timer one selection scan (and a
//   re-arm write if recurring), one final empty scan, then one result per
//   cycle (one result if nothing fired).
// The single read port of the slot memory makes every search over deadlines
// read one slot a cycle. One item is in work at a time.
// Reset disarms all slots, clears the wake latch and last seen time and
// loads the rollover window with one hour. The user must write the window
// register via cfg_we_i / cfg_wdata_i while the block is idle; not enforced.
module deadline_timer_table import dtt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  in_t         in_i,
  output logic        busy,
  output logic        result_valid_o,
  output out_t        result_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_SCAN, S_APPLY, S_EMIT} state_e;
  typedef enum logic [1:0] {M_FRONT, M_DUE, M_SEL, M_MIN} mode_e;

  state_e               state_q;
  mode_e                mode_q;
  in_t                  in_q;
  logic [Slots-1:0]     armed_q, rec_q, due_q;
  logic                 wake_sent_q, roll_q;
  logic [TimeBits-1:0]  last_seen_q, dl_new_q, best_q;
  logic [31:0]          window_q;
  logic [SlotBits-1:0]  s_q, pidx_q, bidx_q;
  logic [SlotBits:0]    cnt_q, n_q, k_q;
  logic                 pend_q, front_q, found_q;
  logic [SlotBits-1:0]  order_q [Slots];

  // memory port
  logic                we_per, we_dl;
  logic [SlotBits-1:0] waddr, raddr;
  slot_ent_t           wdata, rd;

  dtt_slot_ram u_ram (
    .clk_i        (clk_i),
    .we_period_i  (we_per),
    .we_deadline_i(we_dl),
    .waddr_i      (waddr),
    .wdata_i      (wdata),
    .raddr_i      (raddr),
    .rdata_o      (rd)
  );

  logic                accept;
  logic                free_found;
  logic [SlotBits-1:0] free_idx;
  logic                chg;
  logic [TimeBits-1:0] rst_start, rst_dl, per_ext;
  logic                front_c, found_c, last_c, cond;
  logic [TimeBits-1:0] best_c;
  logic [SlotBits-1:0] bidx_c;
  logic [Slots-1:0]    cancel_mask;
  logic                result_valid_d;
  out_t                result_d;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!armed_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotBits'(i);
      end
    end
  end

  assign cancel_mask = armed_q & ~(Slots'(1) << in_i.slot);

  // reset: new start point and whether anything changes
  assign per_ext   = {{(TimeBits - PeriodBits){1'b0}}, rd.period};
  assign chg       = in_q.restart_now || (in_q.period_ms != rd.period);
  assign rst_start = in_q.restart_now ? in_q.now_ms :
                     (rd.deadline >= per_ext) ? rd.deadline - per_ext : '0;
  assign rst_dl    = sat_add(rst_start, in_q.period_ms);

  // one scan step on the word read last cycle
  always_comb begin
    front_c = front_q;
    found_c = found_q;
    best_c  = best_q;
    bidx_c  = bidx_q;
    cond    = (mode_q == M_SEL) ? due_q[pidx_q] : armed_q[pidx_q];
    if (pend_q && mode_q == M_FRONT && armed_q[pidx_q] && pidx_q != s_q &&
        (rd.deadline < dl_new_q || (rd.deadline == dl_new_q && pidx_q < s_q))) begin
      front_c = 1'b0;
    end
    if (pend_q && (mode_q == M_SEL || mode_q == M_MIN) && cond &&
        (!found_q || rd.deadline < best_q)) begin
      found_c = 1'b1;
      best_c  = rd.deadline;
      bidx_c  = pidx_q;
    end
    last_c = pend_q && (pidx_q == SlotBits'(Slots - 1));
  end

  // memory control
  always_comb begin
    we_per = 1'b0;
    we_dl  = 1'b0;
    waddr  = s_q;
    wdata  = '{period: in_q.period_ms, deadline: rst_dl};
    raddr  = cnt_q[SlotBits-1:0];
    unique case (state_q)
      S_IDLE: begin
        raddr = in_i.slot;
        if (accept && in_i.operation == OP_ADD && free_found) begin
          we_per = 1'b1;
          we_dl  = 1'b1;
          waddr  = free_idx;
          wdata  = '{period: in_i.period_ms,
                     deadline: sat_add(in_i.now_ms, in_i.period_ms)};
        end
      end
      S_RD: begin
        if (in_q.operation == OP_REFRESH) begin
          we_dl = 1'b1;
          wdata = '{period: rd.period, deadline: sat_add(in_q.now_ms, rd.period)};
        end else if (chg) begin
          we_per = 1'b1;
          we_dl  = 1'b1;
        end
      end
      S_SCAN: begin
        if (last_c && mode_q == M_SEL) begin
          raddr = bidx_c;  // period of the winner, for re-arm
        end
      end
      S_APPLY: begin
        we_dl = 1'b1;
        waddr = bidx_q;
        wdata = '{period: rd.period, deadline: sat_add(in_q.now_ms, rd.period)};
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // result word of this cycle
  always_comb begin
    result_valid_d = 1'b0;
    result_d       = result_o;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.operation)
            OP_ADD: begin
              if (!free_found) begin
                result_valid_d = 1'b1;
                result_d = mk_res(ST_FULL, '0, 1'b0, '0, |armed_q, 1'b0, 1'b1);
              end
            end
            OP_CANCEL: begin
              result_valid_d = 1'b1;
              if (!armed_q[in_i.slot]) begin
                result_d = mk_res(ST_REFUSED, '0, 1'b0, '0, |armed_q, 1'b0, 1'b1);
              end else begin
                result_d = mk_res(ST_OK, '0, 1'b0, '0, |cancel_mask, 1'b0, 1'b1);
              end
            end
            OP_REFRESH, OP_RESET: begin
              if (!armed_q[in_i.slot]) begin
                result_valid_d = 1'b1;
                result_d = mk_res(ST_REFUSED, '0, 1'b0, '0, |armed_q, 1'b0, 1'b1);
              end
            end
            OP_EXPIRE, OP_QUERY: begin
            end
            default: begin
              result_valid_d = 1'b1;
              result_d = mk_res(ST_REFUSED, '0, 1'b0, '0, |armed_q, 1'b0, 1'b1);
            end
          endcase
        end
      end
      S_RD: begin
        if (!(in_q.operation == OP_RESET && chg)) begin
          result_valid_d = 1'b1;
          result_d = mk_res(ST_OK, '0, 1'b0, '0, |armed_q, 1'b0, 1'b1);
        end
      end
      S_SCAN: begin
        if (last_c) begin
          unique case (mode_q)
            M_FRONT: begin
              result_valid_d = 1'b1;
              result_d = mk_res(ST_OK, (in_q.operation == OP_ADD) ? s_q : '0,
                                1'b0, '0, |armed_q, front_c && !wake_sent_q, 1'b1);
            end
            M_MIN: begin
              result_valid_d = 1'b1;
              result_d = mk_res(ST_OK, '0, 1'b0,
                                !found_c ? TimeMax :
                                (in_q.now_ms >= best_c) ? '0 : best_c - in_q.now_ms,
                                |armed_q, 1'b0, 1'b1);
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        result_valid_d = 1'b1;
        if (n_q == '0) begin
          result_d = mk_res(ST_OK, '0, 1'b0, '0, |armed_q, 1'b0, 1'b1);
        end else begin
          result_d = mk_res(ST_OK, order_q[k_q[SlotBits-1:0]], 1'b1, '0, |armed_q,
                            1'b0, (k_q + 1'b1) == n_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      mode_q         <= M_FRONT;
      armed_q        <= '0;
      rec_q          <= '0;
      due_q          <= '0;
      wake_sent_q    <= 1'b0;
      roll_q         <= 1'b0;
      last_seen_q    <= '0;
      window_q       <= DefaultWindow;
      cnt_q          <= '0;
      n_q            <= '0;
      k_q            <= '0;
      pend_q         <= 1'b0;
      front_q        <= 1'b1;
      found_q        <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= result_valid_d;
      result_o       <= result_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            in_q    <= in_i;
            s_q     <= (in_i.operation == OP_ADD) ? free_idx : in_i.slot;
            cnt_q   <= '0;
            pend_q  <= 1'b0;
            front_q <= 1'b1;
            found_q <= 1'b0;
            unique case (in_i.operation)
              OP_ADD: begin
                if (free_found) begin
                  armed_q[free_idx] <= 1'b1;
                  rec_q[free_idx]   <= in_i.recurring;
                  dl_new_q          <= sat_add(in_i.now_ms, in_i.period_ms);
                  mode_q            <= M_FRONT;
                  state_q           <= S_SCAN;
                end
              end
              OP_CANCEL: begin
                if (armed_q[in_i.slot]) begin
                  armed_q[in_i.slot] <= 1'b0;
                end
              end
              OP_REFRESH, OP_RESET: begin
                if (armed_q[in_i.slot]) begin
                  state_q <= S_RD;
                end
              end
              OP_EXPIRE: begin
                roll_q <= (last_seen_q >= {16'd0, window_q}) &&
                          (in_i.now_ms < last_seen_q - {16'd0, window_q});
                last_seen_q <= in_i.now_ms;
                due_q       <= '0;
                n_q         <= '0;
                mode_q      <= M_DUE;
                state_q     <= S_SCAN;
              end
              OP_QUERY: begin
                mode_q  <= M_MIN;
                state_q <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          if (in_q.operation == OP_RESET && chg) begin
            dl_new_q <= rst_dl;
            mode_q   <= M_FRONT;
            state_q  <= S_SCAN;
          end else begin
            state_q  <= S_IDLE;
          end
        end
        S_SCAN: begin
          best_q <= best_c;
          bidx_q <= bidx_c;
          if (pend_q && mode_q == M_DUE) begin
            due_q[pidx_q] <= armed_q[pidx_q] && (roll_q || rd.deadline <= in_q.now_ms);
          end
          if (last_c) begin
            cnt_q   <= '0;
            pend_q  <= 1'b0;
            found_q <= 1'b0;
            front_q <= 1'b1;
            unique case (mode_q)
              M_FRONT: begin
                wake_sent_q <= wake_sent_q || front_c;
                state_q     <= S_IDLE;
              end
              M_MIN: begin
                wake_sent_q <= 1'b0;
                state_q     <= S_IDLE;
              end
              M_DUE: begin
                mode_q <= M_SEL;
              end
              M_SEL: begin
                if (found_c) begin
                  due_q[bidx_c]            <= 1'b0;
                  order_q[n_q[SlotBits-1:0]] <= bidx_c;
                  n_q                      <= n_q + 1'b1;
                  if (rec_q[bidx_c]) begin
                    state_q <= S_APPLY;
                  end else begin
                    armed_q[bidx_c] <= 1'b0;
                  end
                end else begin
                  k_q     <= '0;
                  state_q <= S_EMIT;
                end
              end
              default: begin
              end
            endcase
          end else begin
            if (cnt_q != (SlotBits + 1)'(Slots)) begin
              cnt_q  <= cnt_q + 1'b1;
              pend_q <= 1'b1;
              pidx_q <= cnt_q[SlotBits-1:0];
            end else begin
              pend_q <= 1'b0;
            end
            front_q <= front_c;
            found_q <= found_c;
          end
        end
        S_APPLY: begin
          state_q <= S_SCAN;  // next selection pass
        end
        S_EMIT: begin
          if (n_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            k_q <= k_q + 1'b1;
            if ((k_q + 1'b1) == n_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fire_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= (SlotBits + 1)'(Slots))
    else $error("more timers fired than slots");
  a_wake_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.wake |-> wake_sent_q)
    else $error("wake given without latch set");
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.fired |-> result_o.status == ST_OK)
    else $error("fired result with bad status");
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy)
    else $error("idle while results still pending");
`endif

endmodule

// ===== tb/sv/tb_deadline_timer_table.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of deadline_timer_table: directed table, a table fill, then random timer traffic.
// Depends on dtt_pkg and the deadline_timer_table RTL.
module tb_deadline_timer_table;
  import dtt_pkg::*;

  localparam int unsigned DirRows    = 22;
  localparam int unsigned RandItems  = 210;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned InBits     = $bits(in_t);

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  in_t         in_i;
  logic        busy;
  logic        result_valid_o;
  out_t        result_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  deadline_timer_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .in_i          (in_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Shadow copy of the timer table
  logic                  sh_armed [Slots];
  logic                  sh_rec   [Slots];
  logic [PeriodBits-1:0] sh_period[Slots];
  logic [TimeBits-1:0]   sh_dl    [Slots];
  logic                  sh_wake_sent;
  logic [TimeBits-1:0]   sh_last_seen;
  logic [31:0]           sh_window;

  out_t exp_words[$];
  int   n_mismatch;
  int   idle_cycles = 0;
  bit   timed_out;
  logic [TimeBits-1:0] clock_ms;   // stimulus time base

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [TimeBits-1:0] add_sat(logic [TimeBits-1:0] t,
                                                  logic [PeriodBits-1:0] p);
    logic [TimeBits:0] s;
    s = {1'b0, t} + (TimeBits + 1)'(p);
    return s[TimeBits] ? {TimeBits{1'b1}} : s[TimeBits-1:0];
  endfunction

  function automatic logic armed_any();
    foreach (sh_armed[i]) if (sh_armed[i]) return 1'b1;
    return 1'b0;
  endfunction

  // slot s ahead of all other armed slots (ties go to the lower index)
  function automatic logic leads(int s);
    for (int i = 0; i < Slots; i++) begin
      if (i == s || !sh_armed[i]) continue;
      if (sh_dl[i] < sh_dl[s]) return 1'b0;
      if (sh_dl[i] == sh_dl[s] && i < s) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic try_wake(int s);
    if (leads(s) && !sh_wake_sent) begin
      sh_wake_sent = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_t word(status_e st, int sl, logic fi,
                                logic [TimeBits-1:0] rem, logic wk, logic la);
    out_t w;
    w.status       = st;
    w.result_slot  = sl[SlotBits-1:0];
    w.fired        = fi;
    w.remaining_ms = rem;
    w.any_armed    = armed_any();
    w.wake         = wk;
    w.last         = la;
    return w;
  endfunction

  // Computes the words a timer operation yields and updates the shadow table.
  task automatic predict_timer_op(input in_t it, output out_t res[$]);
    logic                valid;
    logic                wk;
    logic                rollover;
    logic                due[Slots];
    int                  order[$];
    int                  best;
    logic [TimeBits-1:0] st;
    logic [TimeBits-1:0] earliest;
    logic                found;
    int                  s;
    res.delete();
    s     = it.slot;
    valid = sh_armed[s];
    case (it.operation)
      OP_ADD: begin
        for (int i = 0; i < Slots; i++) begin
          if (!sh_armed[i]) begin
            sh_armed[i]  = 1'b1;
            sh_rec[i]    = it.recurring;
            sh_period[i] = it.period_ms;
            sh_dl[i]     = add_sat(it.now_ms, it.period_ms);
            wk = try_wake(i);
            res = {res, word(ST_OK, i, 1'b0, '0, wk, 1'b1)};
            return;
          end
        end
        res = {res, word(ST_FULL, 0, 1'b0, '0, 1'b0, 1'b1)};
      end
      OP_CANCEL, OP_REFRESH: begin
        if (!valid) res = {res, word(ST_REFUSED, 0, 1'b0, '0, 1'b0, 1'b1)};
        else begin
          if (it.operation == OP_CANCEL) sh_armed[s] = 1'b0;
          else sh_dl[s] = add_sat(it.now_ms, sh_period[s]);
          res = {res, word(ST_OK, 0, 1'b0, '0, 1'b0, 1'b1)};
        end
      end
      OP_RESET: begin
        wk = 1'b0;
        if (!valid) res = {res, word(ST_REFUSED, 0, 1'b0, '0, 1'b0, 1'b1)};
        else begin
          if (it.restart_now || it.period_ms != sh_period[s]) begin
            if (it.restart_now) st = it.now_ms;
            else if (sh_dl[s] >= TimeBits'(sh_period[s])) st = sh_dl[s] - sh_period[s];
            else st = '0;
            sh_period[s] = it.period_ms;
            sh_dl[s]     = add_sat(st, it.period_ms);
            wk = try_wake(s);
          end
          res = {res, word(ST_OK, 0, 1'b0, '0, wk, 1'b1)};
        end
      end
      OP_EXPIRE: begin
        rollover = sh_last_seen >= TimeBits'(sh_window) &&
                   it.now_ms < sh_last_seen - TimeBits'(sh_window);
        sh_last_seen = it.now_ms;
        for (int i = 0; i < Slots; i++)
          due[i] = sh_armed[i] && (rollover || sh_dl[i] <= it.now_ms);
        forever begin
          best = -1;
          for (int i = 0; i < Slots; i++)
            if (due[i] && (best < 0 || sh_dl[i] < sh_dl[best])) best = i;
          if (best < 0) break;
          due[best] = 1'b0;
          order = {order, best};
        end
        foreach (order[k]) begin
          if (sh_rec[order[k]]) sh_dl[order[k]] = add_sat(it.now_ms, sh_period[order[k]]);
          else sh_armed[order[k]] = 1'b0;
        end
        if (order.size() == 0) res = {res, word(ST_OK, 0, 1'b0, '0, 1'b0, 1'b1)};
        foreach (order[k])
          res = {res, word(ST_OK, order[k], 1'b1, '0, 1'b0, k == order.size() - 1)};
      end
      OP_QUERY: begin
        found    = 1'b0;
        earliest = '0;
        for (int i = 0; i < Slots; i++)
          if (sh_armed[i] && (!found || sh_dl[i] < earliest)) begin
            earliest = sh_dl[i];
            found    = 1'b1;
          end
        sh_wake_sent = 1'b0;
        res = {res, word(ST_OK, 0, 1'b0,
                         !found ? {TimeBits{1'b1}} :
                         (it.now_ms >= earliest ? '0 : earliest - it.now_ms),
                         1'b0, 1'b1)};
      end
      default: res = {res, word(ST_REFUSED, 0, 1'b0, '0, 1'b0, 1'b1)};
    endcase
  endtask

  // Result monitor: every strobed word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (exp_words.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected word %p", result_o);
      end else begin
        want = exp_words.pop_front();
        if (result_o !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p, got %p", want, result_o);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("tb_deadline_timer_table failed");
      $finish;
    end
  end

  // Directed rows; hard expectations only for the obvious status codes.
  typedef struct {
    op_e                   op;
    logic [3:0]            slot;
    logic [PeriodBits-1:0] period;
    logic                  rec;
    logic                  restart_now;
    logic [TimeBits-1:0]   now;
    bit                    has_status;
    status_e               status;
  } row_t;

  row_t dir_rows[DirRows];

  function automatic row_t mk_row(op_e op, int sl, logic [PeriodBits-1:0] p, logic r,
                                  logic fn, logic [TimeBits-1:0] t, bit hs, status_e st);
    row_t x;
    x.op = op; x.slot = sl[3:0]; x.period = p; x.rec = r; x.restart_now = fn;
    x.now = t; x.has_status = hs; x.status = st;
    return x;
  endfunction

  // Drives one word, waiting for the handshake; sender idles at random when gappy.
  // start stays high after the handshake until the next word, a gap or a drain.
  task automatic send_word(input in_t it, input bit gappy);
    out_t res[$];
    while (gappy && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      in_i  <= in_t'(InBits'({$urandom(), $urandom(), $urandom()}));
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_timer_op(it, res);
    foreach (res[k]) exp_words = {exp_words, res[k]};
  endtask

  task automatic drain();
    start <= 1'b0;
    in_i  <= in_t'(InBits'({$urandom(), $urandom(), $urandom()}));
    while (exp_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [31:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sh_window = v;
  endtask

  function automatic in_t rand_item();
    in_t it;
    int  pick;
    it = in_t'(InBits'({$urandom(), $urandom(), $urandom()}));
    pick = $urandom_range(0, 99);
    if (pick < 30)      it.operation = OP_ADD;
    else if (pick < 40) it.operation = OP_CANCEL;
    else if (pick < 50) it.operation = OP_REFRESH;
    else if (pick < 62) it.operation = OP_RESET;
    else if (pick < 82) it.operation = OP_EXPIRE;
    else if (pick < 97) it.operation = OP_QUERY;
    else                it.operation = 3'($urandom_range(6, 7));
    // mostly small periods so timers come due; sometimes wide ones
    if ($urandom_range(0, 9) < 8) it.period_ms = PeriodBits'($urandom_range(0, 200));
    // time mostly advances, sometimes jumps back or to the extremes
    pick = $urandom_range(0, 99);
    if (pick < 85) clock_ms = clock_ms + TimeBits'($urandom_range(0, 120));
    else if (pick < 93) clock_ms = clock_ms - TimeBits'($urandom_range(0, 5000000));
    else if (pick < 97) clock_ms = {$urandom(), 16'($urandom())};
    else clock_ms = {TimeBits{1'b1}} - TimeBits'($urandom_range(0, 100));
    it.now_ms = clock_ms;
    return it;
  endfunction

  initial begin
    in_t  it;
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    n_mismatch  = 0;
    clock_ms    = '0;
    foreach (sh_armed[i]) begin
      sh_armed[i] = 1'b0; sh_rec[i] = 1'b0; sh_period[i] = '0; sh_dl[i] = '0;
    end
    sh_wake_sent = 1'b0;
    sh_last_seen = '0;
    sh_window    = DefaultWindow;

    dir_rows = '{
      mk_row(OP_QUERY,   0, 0,        0, 0, 0,           0, ST_OK),      // empty table
      mk_row(OP_CANCEL,  3, 0,        0, 0, 5,           1, ST_REFUSED),
      mk_row(OP_REFRESH, 0, 0,        0, 0, 5,           1, ST_REFUSED),
      mk_row(OP_RESET,   15, 7,       0, 1, 5,           1, ST_REFUSED),
      mk_row(OP_ADD,     0, 100,      1, 0, 10,          1, ST_OK),
      mk_row(OP_ADD,     0, 0,        0, 0, 10,          1, ST_OK),      // zero period
      mk_row(OP_ADD,     0, '1,       0, 0, '1,          1, ST_OK),      // saturating
      mk_row(OP_QUERY,   0, 0,        0, 0, 20,          0, ST_OK),
      mk_row(OP_ADD,     0, 5,        1, 1, 0,           0, ST_OK),      // new earliest
      mk_row(OP_RESET,   0, 100,      0, 0, 30,          0, ST_OK),      // unchanged
      mk_row(OP_RESET,   0, 50,       0, 0, 30,          0, ST_OK),      // from start
      mk_row(OP_RESET,   1, 3,        0, 1, 30,          0, ST_OK),
      mk_row(OP_REFRESH, 2, 0,        0, 0, 40,          0, ST_OK),
      mk_row(OP_EXPIRE,  0, 0,        0, 0, 200,         0, ST_OK),
      mk_row(OP_EXPIRE,  0, 0,        0, 0, 201,         0, ST_OK),
      mk_row(OP_CANCEL,  0, 0,        0, 0, 300,         0, ST_OK),
      mk_row(OP_EXPIRE,  0, 0,        0, 0, 48'd9000000, 0, ST_OK),
      mk_row(OP_EXPIRE,  0, 0,        0, 0, 48'd1000,    0, ST_OK),     // rollover
      mk_row(op_e'(3'd6), 0, 0,       0, 0, 0,           1, ST_REFUSED),
      mk_row(op_e'(3'd7), 9, 0,       1, 1, '1,          1, ST_REFUSED),
      mk_row(OP_QUERY,   0, 0,        0, 0, '1,          0, ST_OK),
      mk_row(OP_ADD,     0, 1,        1, 1, 48'd2000,    0, ST_OK)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      it.operation   = dir_rows[r].op;
      it.slot        = dir_rows[r].slot;
      it.period_ms   = dir_rows[r].period;
      it.recurring   = dir_rows[r].rec;
      it.restart_now = dir_rows[r].restart_now;
      it.now_ms      = dir_rows[r].now;
      send_word(it, 1'b0);
      if (dir_rows[r].has_status && exp_words[$].status != dir_rows[r].status) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("row %0d: model status %0d, table %0d", r,
                                       exp_words[$].status, dir_rows[r].status);
      end
    end

    // Add one timer more than there are slots, so the table fills up, then expire
    drain();
    for (int i = 0; i < Slots + 1; i++) begin
      it = '0;
      it.operation = OP_ADD;
      it.period_ms = 32'($urandom_range(0, 50));
      it.recurring = i[0];
      it.now_ms    = 48'd3000;
      send_word(it, 1'b0);
    end
    it.operation = OP_EXPIRE;
    it.now_ms    = 48'd4000;
    send_word(it, 1'b0);

    // Random phases under several rollover windows, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_window(32'd0);
        1: write_window(32'hFFFF_FFFF);
        2: write_window(32'd1000);
        3: write_window(32'($urandom_range(0, 10000000)));
        default: write_window(DefaultWindow);
      endcase
      for (int n = 0; n < RandItems / 5; n++) begin
        // phase 1 runs without sender gaps
        send_word(rand_item(), ph != 1);
        if (n == 20) drain();  // once per phase the sender waits for every pending word
      end
    end

    drain();
    if (n_mismatch == 0 && exp_words.size() == 0) begin
      $display("tb_deadline_timer_table passed");
    end else begin
      $display("tb_deadline_timer_table failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dtt_pkg.sv
rtl/dtt_slot_ram.sv
rtl/deadline_timer_table.sv
tb/sv/tb_deadline_timer_table.sv
